### rtl/core/rrqt_pkg.sv
`timescale 1ns / 1ps

package rrqt_pkg;

  localparam int PANEL_W_DEF    = 480;
  localparam int PANEL_H_DEF    = 800;
  localparam int BAND_LINES_DEF = 48;
  localparam int CMD_DEPTH      = 4;
  localparam int RES_DEPTH      = 4;

  localparam int XW    = 10;
  localparam int YW    = 9;
  localparam int PIXW  = 16;
  localparam int ADDRW = 16;
  localparam int PXW   = 9;
  localparam int PYW   = 10;
  localparam int HW    = 10;
  localparam int PRODW = 20;
  localparam int SUMW  = 21;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_PIXEL = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_RECT     = 2'd1,
    KIND_FLUSH    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } out_kind_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic [PXW-1:0] x_start;
    logic [PYW-1:0] y_start;
    logic [PXW-1:0] x_end;
    logic [PYW-1:0] y_end;
  } rect_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [XW-1:0]   col;
    logic [YW-1:0]   j;
    logic [HW-1:0]   h;
    logic [PIXW-1:0] pix;
    logic            last_px;
    rect_t           rect;
  } cmd_t;

  typedef struct packed {
    out_kind_t        kind;
    logic [ADDRW-1:0] buf_addr;
    logic [PIXW-1:0]  pix;
    rect_t            rect;
    logic             last;
  } res_t;

endpackage

### rtl/core/region_rotate_quarter_turn.sv
`timescale 1ns / 1ps
// Channel   Ports                       Transfer when
// input     push/full, in_*             push && !full
// result    empty/pop, out_*            pop && !empty
// config    cfg_we, cfg_wdata (flip)    cfg_we
//
// One input item per cycle while full is low; a region's last pixel holds the back end
// while it sends its write result and then its rectangle result. An input transfer passes
// the command queue, multiply, add/compare and result queue write before it reaches the port.
// Reset is synchronous; control state clears directly, with no clearing pass.
// full rises only when the command queue fills; a stalled result holds in the
// result queue while the front keeps accepting.

module region_rotate_quarter_turn import rrqt_pkg::*; #(
  parameter int PANEL_W    = PANEL_W_DEF,
  parameter int PANEL_H    = PANEL_H_DEF,
  parameter int BAND_LINES = BAND_LINES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             push,
  output logic             full,
  input  logic             in_req_type,
  input  logic [XW-1:0]    in_region_x_first,
  input  logic [YW-1:0]    in_region_y_first,
  input  logic [XW-1:0]    in_region_x_last,
  input  logic [YW-1:0]    in_region_y_last,
  input  logic             in_panel_taken,
  input  logic [PIXW-1:0]  in_pixel,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       out_kind,
  output logic [ADDRW-1:0] out_buf_addr,
  output logic [PIXW-1:0]  out_pixel_out,
  output logic [PXW-1:0]   out_panel_x_start,
  output logic [PYW-1:0]   out_panel_y_start,
  output logic [PXW-1:0]   out_panel_x_end,
  output logic [PYW-1:0]   out_panel_y_end,
  output logic             out_last
);

  logic in_xfer;
  logic f_push;
  cmd_t f_data;
  logic q_full, q_empty, q_pop;
  cmd_t q_data;
  logic r_push, r_full;
  res_t r_data;
  res_t out_res;

  assign full    = q_full;
  assign in_xfer = push && !q_full;

  rrqt_front #(
    .PANEL_W (PANEL_W),
    .PANEL_H (PANEL_H)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_xfer           (in_xfer),
    .in_req_type       (in_req_type),
    .in_region_x_first (in_region_x_first),
    .in_region_y_first (in_region_y_first),
    .in_region_x_last  (in_region_x_last),
    .in_region_y_last  (in_region_y_last),
    .in_panel_taken    (in_panel_taken),
    .in_pixel          (in_pixel),
    .q_push            (f_push),
    .q_data            (f_data)
  );

  rrqt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  rrqt_back #(
    .PANEL_H    (PANEL_H),
    .BAND_LINES (BAND_LINES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_data  (r_data)
  );

  rrqt_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_data),
    .full  (r_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_kind          = out_res.kind;
  assign out_buf_addr      = out_res.buf_addr;
  assign out_pixel_out     = out_res.pix;
  assign out_panel_x_start = out_res.rect.x_start;
  assign out_panel_y_start = out_res.rect.y_start;
  assign out_panel_x_end   = out_res.rect.x_end;
  assign out_panel_y_end   = out_res.rect.y_end;
  assign out_last          = out_res.last;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_FLUSH || out_kind == KIND_RECT)) |-> out_last)
    else $error("flush or rectangle result without last");

  a_ovf_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_OVERFLOW) |-> (out_buf_addr == '0))
    else $error("overflow result carries an address");

  a_rect_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && (out_kind == KIND_WRITE || out_kind == KIND_OVERFLOW) && !out_last)
    |=> !(!empty && out_kind == KIND_FLUSH))
    else $error("region interrupted by flush result");

endmodule

### rtl/core/rrqt_fifo.sv
`timescale 1ns / 1ps

module rrqt_fifo import rrqt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + PW'(1) : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + PW'(1) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

### rtl/core/rrqt_front.sv
`timescale 1ns / 1ps

module rrqt_front import rrqt_pkg::*; #(
  parameter int PANEL_W = PANEL_W_DEF,
  parameter int PANEL_H = PANEL_H_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            in_xfer,
  input  logic            in_req_type,
  input  logic [XW-1:0]   in_region_x_first,
  input  logic [YW-1:0]   in_region_y_first,
  input  logic [XW-1:0]   in_region_x_last,
  input  logic [YW-1:0]   in_region_y_last,
  input  logic            in_panel_taken,
  input  logic [PIXW-1:0] in_pixel,
  output logic            q_push,
  output cmd_t            q_data
);

  logic          flip_r, flip_nxt;
  logic [XW-1:0] left_r, left_nxt;
  logic [XW-1:0] right_r, right_nxt;
  logic [YW-1:0] top_r, top_nxt;
  logic [YW-1:0] bottom_r, bottom_nxt;
  logic [XW-1:0] cur_col_r, cur_col_nxt;
  logic [YW-1:0] cur_row_r, cur_row_nxt;
  logic          active_r, active_nxt;

  logic          is_pixel;
  logic          bad;
  logic          last_px;
  logic [XW-1:0] col;
  logic [YW-1:0] j;
  logic [HW-1:0] h;
  rect_t         rect;

  assign is_pixel = (in_req_type == REQ_PIXEL);

  assign bad = in_panel_taken
            || (in_region_x_last < in_region_x_first)
            || (in_region_y_last < in_region_y_first)
            || ({2'b00, in_region_x_last} >= 12'(PANEL_H))
            || ({2'b00, in_region_y_last} >= 11'(PANEL_W));

  assign last_px = (cur_col_r == right_r) && (cur_row_r == bottom_r);
  assign h       = {1'b0, bottom_r} - {1'b0, top_r} + HW'(1);

  always_comb begin
    if (flip_r) begin
      col          = right_r - cur_col_r;
      j            = cur_row_r - top_r;
      rect.x_start = top_r;
      rect.y_start = PYW'(12'(PANEL_H - 1) - {2'b00, right_r});
      rect.x_end   = bottom_r + PXW'(1);
      rect.y_end   = PYW'(12'(PANEL_H) - {2'b00, left_r});
    end else begin
      col          = cur_col_r - left_r;
      j            = bottom_r - cur_row_r;
      rect.x_start = PXW'(11'(PANEL_W - 1) - {2'b00, bottom_r});
      rect.y_start = left_r;
      rect.x_end   = PXW'(11'(PANEL_W) - {2'b00, top_r});
      rect.y_end   = right_r + PYW'(1);
    end
  end

  always_comb begin
    q_data.kind    = is_pixel ? CMD_PIXEL : CMD_FLUSH;
    q_data.col     = col;
    q_data.j       = j;
    q_data.h       = h;
    q_data.pix     = in_pixel;
    q_data.last_px = last_px;
    q_data.rect    = rect;
    q_push         = in_xfer && (is_pixel ? active_r : bad);
  end

  always_comb begin
    flip_nxt    = cfg_we ? cfg_wdata : flip_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    top_nxt     = top_r;
    bottom_nxt  = bottom_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    active_nxt  = active_r;
    if (in_xfer) begin
      if (!is_pixel) begin
        left_nxt    = in_region_x_first;
        right_nxt   = in_region_x_last;
        top_nxt     = in_region_y_first;
        bottom_nxt  = in_region_y_last;
        cur_col_nxt = in_region_x_first;
        cur_row_nxt = in_region_y_first;
        active_nxt  = !bad;
      end else if (active_r) begin
        if (last_px) begin
          active_nxt = 1'b0;
        end else if (cur_col_r == right_r) begin
          cur_col_nxt = left_r;
          cur_row_nxt = cur_row_r + YW'(1);
        end else begin
          cur_col_nxt = cur_col_r + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r    <= 1'b0;
      left_r    <= '0;
      right_r   <= '0;
      top_r     <= '0;
      bottom_r  <= '0;
      cur_col_r <= '0;
      cur_row_r <= '0;
      active_r  <= 1'b0;
    end else begin
      flip_r    <= flip_nxt;
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      top_r     <= top_nxt;
      bottom_r  <= bottom_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      active_r  <= active_nxt;
    end
  end

endmodule

### rtl/core/rrqt_back.sv
`timescale 1ns / 1ps

module rrqt_back import rrqt_pkg::*; #(
  parameter int PANEL_H    = PANEL_H_DEF,
  parameter int BAND_LINES = BAND_LINES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_data,
  output logic q_pop,
  input  logic r_full,
  output logic r_push,
  output res_t r_data
);

  localparam logic [SUMW-1:0] BUF_SIZE = SUMW'(PANEL_H * BAND_LINES);

  logic             a_valid_r, a_valid_nxt;
  cmd_t             a_cmd_r;
  logic [PRODW-1:0] a_prod_r;

  logic             b_valid_r, b_valid_nxt;
  cmd_t             b_cmd_r;
  logic [PRODW-1:0] b_prod_r;
  logic             b_phase_r, b_phase_nxt;

  logic             two_res;
  logic             b_done, b_free, a_move, a_free;
  logic [SUMW-1:0]  addr;
  logic             ovf;

  assign two_res = (b_cmd_r.kind == CMD_PIXEL) && b_cmd_r.last_px;
  assign r_push  = b_valid_r && !r_full;
  assign b_done  = r_push && !(two_res && !b_phase_r);
  assign b_free  = !b_valid_r || b_done;
  assign a_move  = a_valid_r && b_free;
  assign a_free  = !a_valid_r || a_move;
  assign q_pop   = q_valid && a_free;

  assign addr = {1'b0, b_prod_r} + SUMW'(b_cmd_r.j);
  assign ovf  = (addr >= BUF_SIZE);

  always_comb begin
    r_data.kind     = KIND_FLUSH;
    r_data.buf_addr = '0;
    r_data.pix      = '0;
    r_data.rect     = '0;
    r_data.last     = 1'b1;
    case (b_cmd_r.kind)
      CMD_FLUSH: begin
        r_data.kind = KIND_FLUSH;
      end
      default: begin
        if (b_phase_r) begin
          r_data.kind = KIND_RECT;
          r_data.rect = b_cmd_r.rect;
        end else begin
          r_data.kind     = ovf ? KIND_OVERFLOW : KIND_WRITE;
          r_data.buf_addr = ovf ? '0 : addr[ADDRW-1:0];
          r_data.pix      = b_cmd_r.pix;
          r_data.last     = !b_cmd_r.last_px;
        end
      end
    endcase
  end

  always_comb begin
    a_valid_nxt = q_pop ? 1'b1 : (a_move ? 1'b0 : a_valid_r);
    b_valid_nxt = a_move ? 1'b1 : (b_done ? 1'b0 : b_valid_r);
    b_phase_nxt = b_phase_r;
    if (a_move) begin
      b_phase_nxt = 1'b0;
    end else if (r_push && two_res && !b_phase_r) begin
      b_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      b_phase_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      b_phase_r <= b_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_cmd_r  <= q_data;
      a_prod_r <= PRODW'(q_data.col) * PRODW'(q_data.h);
    end
    if (a_move) begin
      b_cmd_r  <= a_cmd_r;
      b_prod_r <= a_prod_r;
    end
  end

endmodule

### dv/region_rotate_checker.sv
`timescale 1ns / 1ps

module region_rotate_checker import rrqt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             push,
  input  logic             full,
  input  logic             in_req_type,
  input  logic [XW-1:0]    in_region_x_first,
  input  logic [YW-1:0]    in_region_y_first,
  input  logic [XW-1:0]    in_region_x_last,
  input  logic [YW-1:0]    in_region_y_last,
  input  logic             in_panel_taken,
  input  logic [PIXW-1:0]  in_pixel,
  input  logic             empty,
  input  logic             pop,
  input  logic [1:0]       out_kind,
  input  logic [ADDRW-1:0] out_buf_addr,
  input  logic [PIXW-1:0]  out_pixel_out,
  input  logic [PXW-1:0]   out_panel_x_start,
  input  logic [PYW-1:0]   out_panel_y_start,
  input  logic [PXW-1:0]   out_panel_x_end,
  input  logic [PYW-1:0]   out_panel_y_end,
  input  logic             out_last,
  output int               mismatches,
  output int               in_flight
);

  localparam int BUF_PIXELS = PANEL_H_DEF * BAND_LINES_DEF;

  logic          flip;
  logic [XW-1:0] left_col, right_col, cur_col;
  logic [YW-1:0] top_row, bottom_row, cur_row;
  logic          active;
  res_t          rotated_q[$];

  function automatic res_t make_res(input out_kind_t kind, input logic [ADDRW-1:0] addr,
                                    input logic [PIXW-1:0] pix, input rect_t rect,
                                    input logic last);
    res_t r;
    r.kind     = kind;
    r.buf_addr = addr;
    r.pix      = pix;
    r.rect     = rect;
    r.last     = last;
    return r;
  endfunction

  task automatic open_region();
    logic refused;
    left_col   = in_region_x_first;
    top_row    = in_region_y_first;
    right_col  = in_region_x_last;
    bottom_row = in_region_y_last;
    cur_col    = in_region_x_first;
    cur_row    = in_region_y_first;
    refused = in_panel_taken || (in_region_x_last < in_region_x_first) ||
              (in_region_y_last < in_region_y_first) ||
              (in_region_x_last >= PANEL_H_DEF) || (in_region_y_last >= PANEL_W_DEF);
    active = !refused;
    if (refused) begin
      rotated_q.push_back(make_res(KIND_FLUSH, '0, '0, '0, 1'b1));
    end
  endtask

  task automatic rotate_pixel();
    int    h;
    int    col;
    int    j;
    int    addr;
    logic  fin;
    rect_t rect;
    if (active) begin
      h = int'(bottom_row) - int'(top_row) + 1;
      if (flip) begin
        col = int'(right_col) - int'(cur_col);
        j   = int'(cur_row) - int'(top_row);
      end else begin
        col = int'(cur_col) - int'(left_col);
        j   = int'(bottom_row) - int'(cur_row);
      end
      addr = col * h + j;
      fin  = (cur_col == right_col) && (cur_row == bottom_row);
      if (addr < BUF_PIXELS) begin
        rotated_q.push_back(make_res(KIND_WRITE, ADDRW'(addr), in_pixel, '0, !fin));
      end else begin
        rotated_q.push_back(make_res(KIND_OVERFLOW, '0, in_pixel, '0, !fin));
      end
      if (fin) begin
        if (flip) begin
          rect.x_start = PXW'(top_row);
          rect.y_start = PYW'(PANEL_H_DEF - 1 - int'(right_col));
          rect.x_end   = PXW'(int'(bottom_row) + 1);
          rect.y_end   = PYW'(PANEL_H_DEF - int'(left_col));
        end else begin
          rect.x_start = PXW'(PANEL_W_DEF - 1 - int'(bottom_row));
          rect.y_start = PYW'(left_col);
          rect.x_end   = PXW'(PANEL_W_DEF - int'(top_row));
          rect.y_end   = PYW'(int'(right_col) + 1);
        end
        rotated_q.push_back(make_res(KIND_RECT, '0, '0, rect, 1'b1));
        active = 1'b0;
      end else if (cur_col == right_col) begin
        cur_col = left_col;
        cur_row = cur_row + 1'b1;
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic match_output();
    res_t w;
    if (rotated_q.size() == 0) begin
      $error("unexpected result transfer: out_kind %0d", out_kind);
      mismatches++;
    end else begin
      w = rotated_q.pop_front();
      check_field("out_kind", 16'(w.kind), 16'(out_kind));
      check_field("out_buf_addr", w.buf_addr, out_buf_addr);
      check_field("out_pixel_out", w.pix, out_pixel_out);
      check_field("out_panel_x_start", 16'(w.rect.x_start), 16'(out_panel_x_start));
      check_field("out_panel_y_start", 16'(w.rect.y_start), 16'(out_panel_y_start));
      check_field("out_panel_x_end", 16'(w.rect.x_end), 16'(out_panel_x_end));
      check_field("out_panel_y_end", 16'(w.rect.y_end), 16'(out_panel_y_end));
      check_field("out_last", 16'(w.last), 16'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      flip       = 1'b0;
      left_col   = '0;
      top_row    = '0;
      right_col  = '0;
      bottom_row = '0;
      cur_col    = '0;
      cur_row    = '0;
      active     = 1'b0;
      mismatches = 0;
      rotated_q.delete();
    end else begin
      if (cfg_we) begin
        flip = cfg_wdata;
      end
      if (push && !full) begin
        if (in_req_type == REQ_START) begin
          open_region();
        end else begin
          rotate_pixel();
        end
      end
      if (pop && !empty) begin
        match_output();
      end
    end
    in_flight = rotated_q.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rrqt_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_ITEMS   = 1700;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_CYCLES  = 200;

  logic             clk               = 1'b0;
  logic             rst_n             = 1'b0;
  logic             cfg_we            = 1'b0;
  logic             cfg_wdata         = 1'b0;
  logic             push              = 1'b0;
  logic             full;
  logic             in_req_type       = 1'b0;
  logic [XW-1:0]    in_region_x_first = '0;
  logic [YW-1:0]    in_region_y_first = '0;
  logic [XW-1:0]    in_region_x_last  = '0;
  logic [YW-1:0]    in_region_y_last  = '0;
  logic             in_panel_taken    = 1'b0;
  logic [PIXW-1:0]  in_pixel          = '0;
  logic             empty;
  logic             pop               = 1'b0;
  logic [1:0]       out_kind;
  logic [ADDRW-1:0] out_buf_addr;
  logic [PIXW-1:0]  out_pixel_out;
  logic [PXW-1:0]   out_panel_x_start;
  logic [PYW-1:0]   out_panel_y_start;
  logic [PXW-1:0]   out_panel_x_end;
  logic [PYW-1:0]   out_panel_y_end;
  logic             out_last;

  int   mismatches;
  int   in_flight;
  int   n_accepted  = 0;
  int   n_items     = 0;
  bit   tx_idle     = 1'b1;
  bit   rx_idle     = 1'b1;
  bit   region_open = 1'b0;
  logic flip_now    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  region_rotate_quarter_turn u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_req_type       (in_req_type),
    .in_region_x_first (in_region_x_first),
    .in_region_y_first (in_region_y_first),
    .in_region_x_last  (in_region_x_last),
    .in_region_y_last  (in_region_y_last),
    .in_panel_taken    (in_panel_taken),
    .in_pixel          (in_pixel),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_buf_addr      (out_buf_addr),
    .out_pixel_out     (out_pixel_out),
    .out_panel_x_start (out_panel_x_start),
    .out_panel_y_start (out_panel_y_start),
    .out_panel_x_end   (out_panel_x_end),
    .out_panel_y_end   (out_panel_y_end),
    .out_last          (out_last)
  );

  region_rotate_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_req_type       (in_req_type),
    .in_region_x_first (in_region_x_first),
    .in_region_y_first (in_region_y_first),
    .in_region_x_last  (in_region_x_last),
    .in_region_y_last  (in_region_y_last),
    .in_panel_taken    (in_panel_taken),
    .in_pixel          (in_pixel),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_buf_addr      (out_buf_addr),
    .out_pixel_out     (out_pixel_out),
    .out_panel_x_start (out_panel_x_start),
    .out_panel_y_start (out_panel_y_start),
    .out_panel_x_end   (out_panel_x_end),
    .out_panel_y_end   (out_panel_y_end),
    .out_last          (out_last),
    .mismatches        (mismatches),
    .in_flight         (in_flight)
  );

  task automatic xfer(input req_kind_t req, input logic [XW-1:0] x0, input logic [YW-1:0] y0,
                      input logic [XW-1:0] x1, input logic [YW-1:0] y1, input logic taken,
                      input logic [PIXW-1:0] pix, input bit counted);
    while (tx_idle && $urandom_range(0, 99) < 10) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push              <= 1'b1;
    in_req_type       <= req;
    in_region_x_first <= x0;
    in_region_y_first <= y0;
    in_region_x_last  <= x1;
    in_region_y_last  <= y1;
    in_panel_taken    <= taken;
    in_pixel          <= pix;
    do @(posedge clk); while (full);
    n_accepted++;
    if (counted) begin
      n_items++;
    end
    @(negedge clk);
  endtask

  task automatic send_pixel(input bit counted);
    xfer(REQ_PIXEL, XW'($urandom_range(0, 1023)), YW'($urandom_range(0, 511)),
         XW'($urandom_range(0, 1023)), YW'($urandom_range(0, 511)),
         1'($urandom_range(0, 1)), PIXW'($urandom_range(0, 65535)), counted);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (in_flight != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_flip(input logic value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    flip_now  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_region(input int x0, input int y0, input int w, input int h,
                            input int count);
    xfer(REQ_START, XW'(x0), YW'(y0), XW'(x0 + w - 1), YW'(y0 + h - 1), 1'b0,
         PIXW'($urandom_range(0, 65535)), 1'b1);
    region_open = 1'b1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 299) == 0) begin
        set_flip(!flip_now);
      end
      send_pixel(1'b1);
    end
    if (count == w * h) begin
      region_open = 1'b0;
    end
  endtask

  task automatic refuse_start();
    int   x0;
    int   y0;
    int   x1;
    int   y1;
    logic taken;
    x0    = $urandom_range(0, 799);
    y0    = $urandom_range(0, 479);
    x1    = $urandom_range(x0, 799);
    y1    = $urandom_range(y0, 479);
    taken = 1'b0;
    case ($urandom_range(0, 4))
      0: begin
        taken = 1'b1;
        x0 = $urandom_range(0, 1023);
        y0 = $urandom_range(0, 511);
        x1 = $urandom_range(0, 1023);
        y1 = $urandom_range(0, 511);
      end
      1: begin
        x0 = $urandom_range(1, 1023);
        x1 = $urandom_range(0, x0 - 1);
      end
      2: begin
        y0 = $urandom_range(1, 511);
        y1 = $urandom_range(0, y0 - 1);
      end
      3: begin
        x1 = $urandom_range(800, 1023);
        x0 = $urandom_range(0, x1);
      end
      default: begin
        y1 = $urandom_range(480, 511);
        y0 = $urandom_range(0, y1);
      end
    endcase
    xfer(REQ_START, XW'(x0), YW'(y0), XW'(x1), YW'(y1), taken,
         PIXW'($urandom_range(0, 65535)), 1'b1);
    region_open = 1'b0;
    repeat ($urandom_range(0, 3)) send_pixel(1'b0);
  endtask

  // receiver: random pop, plus two long hold-offs while the sender keeps pushing
  initial begin
    int holds;
    int hold_left;
    holds     = 0;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if ((holds == 0 && n_accepted >= 500) || (holds == 1 && n_accepted >= 1300)) begin
        pop <= 1'b0;
        hold_left = HOLD_CYCLES;
        holds++;
      end else begin
        pop <= !(rx_idle && $urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin
    int sel;
    int pick;
    int w;
    int h;
    int x0;
    int y0;
    int x1;
    int y1;
    int phase;
    int next_phase;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pixel(1'b0);
    xfer(REQ_START, 0, 0, 0, 0, 1'b0, 16'h0000, 1'b1);
    xfer(REQ_PIXEL, 0, 0, 0, 0, 1'b0, 16'hFFFF, 1'b1);
    xfer(REQ_START, 799, 479, 799, 479, 1'b0, 16'hFFFF, 1'b1);
    xfer(REQ_PIXEL, 1023, 511, 1023, 511, 1'b1, 16'h0000, 1'b1);
    xfer(REQ_START, 0, 0, 5, 5, 1'b1, 16'h0000, 1'b1);
    send_pixel(1'b0);
    xfer(REQ_START, 5, 0, 4, 0, 1'b0, 16'h0000, 1'b1);
    xfer(REQ_START, 0, 7, 0, 6, 1'b0, 16'h0000, 1'b1);
    xfer(REQ_START, 0, 0, 800, 0, 1'b0, 16'h0000, 1'b1);
    xfer(REQ_START, 0, 0, 0, 480, 1'b0, 16'h0000, 1'b1);
    xfer(REQ_START, 1023, 511, 1023, 511, 1'b0, 16'h0000, 1'b1);
    run_region(10, 20, 2, 2, 4);
    set_flip(1'b1);
    // first pixel lands exactly one past the buffer, the second just inside
    run_region(0, 0, 81, 480, 2);
    run_region(100, 100, 2, 1, 1);
    set_flip(1'b0);
    send_pixel(1'b1);
    region_open = 1'b0;

    phase      = 0;
    next_phase = n_items + PHASE_ITEMS;
    while (n_items < RAND_ITEMS) begin
      if (n_items >= next_phase) begin
        phase++;
        next_phase += PHASE_ITEMS;
        set_flip(1'($urandom_range(0, 1)));
        tx_idle = (phase != 3);
        rx_idle = (phase != 3);
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        w    = $urandom_range(1, 6);
        h    = $urandom_range(1, 6);
        pick = $urandom_range(0, 9);
        x0   = (pick == 0) ? 0 : (pick == 1) ? PANEL_H_DEF - w : $urandom_range(0, PANEL_H_DEF - w);
        pick = $urandom_range(0, 9);
        y0   = (pick == 0) ? 0 : (pick == 1) ? PANEL_W_DEF - h : $urandom_range(0, PANEL_W_DEF - h);
        run_region(x0, y0, w, h, ($urandom_range(0, 19) == 0) ? $urandom_range(0, w * h - 1) : w * h);
      end else if (sel < 78) begin
        if ($urandom_range(0, 1)) begin
          w = $urandom_range(1, 60);
          h = 1;
        end else begin
          w = 1;
          h = $urandom_range(1, 60);
        end
        run_region($urandom_range(0, PANEL_H_DEF - w), $urandom_range(0, PANEL_W_DEF - h), w, h, w * h);
      end else if (sel < 82) begin
        // wide tall region: leave it open after the first row segment
        x0 = $urandom_range(0, 40);
        x1 = $urandom_range(700, 799);
        y0 = $urandom_range(0, 20);
        y1 = $urandom_range(400, 479);
        run_region(x0, y0, x1 - x0 + 1, y1 - y0 + 1, $urandom_range(20, 100));
      end else if (sel < 92 || region_open) begin
        refuse_start();
      end else begin
        repeat ($urandom_range(1, 3)) send_pixel(1'b0);
      end
    end

    settle();
    if (mismatches == 0 && in_flight == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
